[rtl/core/natural_order_name_compare_assert.svh]
// ---------------------------------------------------------------------------
// natural_order_name_compare assertion macros
// Clocked property shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef NATURAL_ORDER_NAME_COMPARE_ASSERT_SVH
`define NATURAL_ORDER_NAME_COMPARE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define NOCMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define NOCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/nocmp_pkg.sv]
// ---------------------------------------------------------------------------
// nocmp_pkg
// Payload types and codes of the natural order name comparator.
// ---------------------------------------------------------------------------
package nocmp_pkg;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPARE     = 2'd2;

  localparam logic [1:0] KIND_FILE = 2'd0;
  localparam logic [1:0] KIND_DIR  = 2'd1;

  localparam logic [1:0] ORDER_BEFORE = 2'd0;
  localparam logic [1:0] ORDER_EQUAL  = 2'd1;
  localparam logic [1:0] ORDER_AFTER  = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [62:0] NUM_SAT_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] name_byte;
    logic [1:0] first_kind;
    logic [1:0] second_kind;
  } nocmp_in_t;

  typedef struct packed {
    logic [1:0] order;
    logic       name_truncated;
  } nocmp_out_t;

endpackage

[rtl/core/natural_order_name_compare.sv]
// ---------------------------------------------------------------------------
// natural_order_name_compare
// Loads two entry names into two byte stores and orders the entries:
// directory before file, otherwise names in natural order.
// ---------------------------------------------------------------------------
//   channel | dir | payload     | flow control
//   --------+-----+-------------+---------------------------
//   in      | in  | nocmp_in_t  | in_valid_i / in_stall_o
//   out     | out | nocmp_out_t | out_valid_o / out_stall_i
//
// a load writes the byte to its store at the name length, or sets the truncation flag when full.
// a compare by name checks both lengths, then reads and evaluates a byte pair (ST_CHK, ST_EVAL),
// and walks each digit run through ST_NRD and ST_NEVAL; each step is one read of both stores.
// a decisive kind pair goes straight to ST_FIN; the result is held until out is free.
// reset clears lengths, truncation flag and control; the stores are not cleared.
// input is stalled from compare start until the result is in the output register.
module natural_order_name_compare #(
  parameter int unsigned MAX_NAME_BYTES = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  nocmp_pkg::nocmp_in_t   in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output nocmp_pkg::nocmp_out_t  out_o
);

  import nocmp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NAME_BYTES);
  localparam int unsigned LW = $clog2(MAX_NAME_BYTES + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_NAME_BYTES);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHK   = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_NRD   = 6'b001000,
    ST_NEVAL = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [7:0] fold_char(logic [7:0] c);
    logic [7:0] f;
    f = c;
    if ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z)) begin
      f = c - CHAR_LOW_A + CHAR_UP_A;
    end
    if (f == CHAR_DOT) begin
      f = CHAR_SPACE;
    end else if (f == CHAR_SPACE) begin
      f = CHAR_DOT;
    end
    return f;
  endfunction

  // returns {sat, value}; saturates once value*10+digit passes 2^63-1
  function automatic logic [63:0] acc_step(logic sat, logic [62:0] v, logic [7:0] c);
    logic [66:0] nxt;
    nxt = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {63'b0, c[3:0]};
    if (sat || (nxt[66:63] != 4'b0)) begin
      return {1'b1, v};
    end
    return {1'b0, nxt[62:0]};
  endfunction

  state_e      state_q, state_d;
  logic [LW-1:0] len1_q, len1_d, len2_q, len2_d;
  logic [LW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic        trunc_q, trunc_d;
  logic [62:0] acc1_q, acc1_d, acc2_q, acc2_d;
  logic        sat1_q, sat1_d, sat2_q, sat2_d;
  logic        done1_q, done1_d, done2_q, done2_d;
  logic [1:0]  res_q, res_d;
  logic        out_valid_q;
  nocmp_out_t  out_q;

  logic        in_acc, fin_load;
  logic        we1, we2, rd_en;
  logic [7:0]  rd1, rd2;
  logic [7:0]  f1, f2;
  logic [62:0] n1, n2;
  logic        a1, a2;
  logic [63:0] step1, step2;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign f1    = fold_char(rd1);
  assign f2    = fold_char(rd2);
  assign n1    = sat1_q ? NUM_SAT_MAX : acc1_q;
  assign n2    = sat2_q ? NUM_SAT_MAX : acc2_q;
  assign a1    = !done1_q && (p1_q < len1_q);
  assign a2    = !done2_q && (p2_q < len2_q);
  assign step1 = acc_step(sat1_q, acc1_q, rd1);
  assign step2 = acc_step(sat2_q, acc2_q, rd2);

  nocmp_name_ram #(.Depth(MAX_NAME_BYTES), .AddrW(AW)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (len1_q[AW-1:0]),
    .wdata_i (in_i.name_byte),
    .re_i    (rd_en),
    .raddr_i (p1_q[AW-1:0]),
    .rdata_o (rd1)
  );

  nocmp_name_ram #(.Depth(MAX_NAME_BYTES), .AddrW(AW)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (len2_q[AW-1:0]),
    .wdata_i (in_i.name_byte),
    .re_i    (rd_en),
    .raddr_i (p2_q[AW-1:0]),
    .rdata_o (rd2)
  );

  always_comb begin
    state_d = state_q;
    len1_d  = len1_q;
    len2_d  = len2_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    trunc_d = trunc_q;
    acc1_d  = acc1_q;
    acc2_d  = acc2_q;
    sat1_d  = sat1_q;
    sat2_d  = sat2_q;
    done1_d = done1_q;
    done2_d = done2_q;
    res_d   = res_q;
    we1     = 1'b0;
    we2     = 1'b0;
    rd_en   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.command)
            CMD_LOAD_FIRST: begin
              if (len1_q < LEN_MAX) begin
                we1    = 1'b1;
                len1_d = len1_q + LW'(1);
              end else begin
                trunc_d = 1'b1;
              end
            end
            CMD_LOAD_SECOND: begin
              if (len2_q < LEN_MAX) begin
                we2    = 1'b1;
                len2_d = len2_q + LW'(1);
              end else begin
                trunc_d = 1'b1;
              end
            end
            CMD_COMPARE: begin
              p1_d = '0;
              p2_d = '0;
              if ((in_i.first_kind == KIND_FILE) && (in_i.second_kind == KIND_DIR)) begin
                res_d   = ORDER_AFTER;
                state_d = ST_FIN;
              end else if ((in_i.first_kind == KIND_DIR) &&
                           (in_i.second_kind == KIND_FILE)) begin
                res_d   = ORDER_BEFORE;
                state_d = ST_FIN;
              end else begin
                state_d = ST_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHK: begin
        if ((p1_q >= len1_q) && (p2_q >= len2_q)) begin
          res_d   = ORDER_EQUAL;
          state_d = ST_FIN;
        end else if (p1_q >= len1_q) begin
          res_d   = ORDER_BEFORE;
          state_d = ST_FIN;
        end else if (p2_q >= len2_q) begin
          res_d   = ORDER_AFTER;
          state_d = ST_FIN;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (is_digit(rd1) && is_digit(rd2)) begin
          // first digit of each run is already at hand
          acc1_d  = {59'b0, rd1[3:0]};
          acc2_d  = {59'b0, rd2[3:0]};
          sat1_d  = 1'b0;
          sat2_d  = 1'b0;
          done1_d = 1'b0;
          done2_d = 1'b0;
          p1_d    = p1_q + LW'(1);
          p2_d    = p2_q + LW'(1);
          state_d = ST_NRD;
        end else if (f1 != f2) begin
          res_d   = ($signed(f1) < $signed(f2)) ? ORDER_BEFORE : ORDER_AFTER;
          state_d = ST_FIN;
        end else begin
          p1_d    = p1_q + LW'(1);
          p2_d    = p2_q + LW'(1);
          state_d = ST_CHK;
        end
      end
      ST_NRD: begin
        done1_d = !a1;
        done2_d = !a2;
        if (!a1 && !a2) begin
          if (n1 != n2) begin
            res_d   = (n1 < n2) ? ORDER_BEFORE : ORDER_AFTER;
            state_d = ST_FIN;
          end else begin
            state_d = ST_CHK;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = ST_NEVAL;
        end
      end
      ST_NEVAL: begin
        if (!done1_q) begin
          if (is_digit(rd1)) begin
            sat1_d = step1[63];
            acc1_d = step1[62:0];
            p1_d   = p1_q + LW'(1);
          end else begin
            done1_d = 1'b1;
          end
        end
        if (!done2_q) begin
          if (is_digit(rd2)) begin
            sat2_d = step2[63];
            acc2_d = step2[62:0];
            p2_d   = p2_q + LW'(1);
          end else begin
            done2_d = 1'b1;
          end
        end
        state_d = ST_NRD;
      end
      ST_FIN: begin
        if (fin_load) begin
          len1_d  = '0;
          len2_d  = '0;
          trunc_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len1_q      <= '0;
      len2_q      <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len1_q  <= len1_d;
      len2_q  <= len2_d;
      trunc_q <= trunc_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    acc1_q  <= acc1_d;
    acc2_q  <= acc2_d;
    sat1_q  <= sat1_d;
    sat2_q  <= sat2_d;
    done1_q <= done1_d;
    done2_q <= done2_d;
    res_q   <= res_d;
    if (fin_load) begin
      out_q.order          <= res_q;
      out_q.name_truncated <= trunc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/core/nocmp_name_ram.sv]
// ---------------------------------------------------------------------------
// nocmp_name_ram
// One name store: single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module nocmp_name_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/nocmp_checker.sv]
// ---------------------------------------------------------------------------
// nocmp_checker
// Port-level checks of the natural order name comparator, bound to the top.
// ---------------------------------------------------------------------------
`include "natural_order_name_compare_assert.svh"

module nocmp_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input nocmp_pkg::nocmp_in_t  in_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input nocmp_pkg::nocmp_out_t out_o
);

  import nocmp_pkg::*;

  // a held result keeps its payload
  `NOCMP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "out payload changed while stalled")

  // only the three order codes are ever shown
  `NOCMP_ASSERT_NOW(a_order_code, out_valid_o, (out_o.order == ORDER_BEFORE) || (out_o.order == ORDER_EQUAL) || (out_o.order == ORDER_AFTER), "bad order code")

  // a load transfer never brings up a result
  `NOCMP_ASSERT_NEXT(a_load_no_result, in_valid_i && !in_stall_o && (in_i.command != CMD_COMPARE) && !out_valid_o, !out_valid_o, "result after a load")

  // a compare transfer leaves the input stalled
  `NOCMP_ASSERT_NEXT(a_cmp_busy, in_valid_i && !in_stall_o && (in_i.command == CMD_COMPARE), in_stall_o, "input open during compare")

endmodule

bind natural_order_name_compare nocmp_checker u_nocmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
